// ----- design/lepr_pkg.sv -----
// ---------------------------------------------------------------------------
// LED effect renderer package
// Shared types, codes and arithmetic helpers of the pixel renderer.
// ---------------------------------------------------------------------------
`default_nettype none

package lepr_pkg;

    typedef enum logic [2:0] {
        MODE_OFF       = 3'd0,
        MODE_STATIC    = 3'd1,
        MODE_BREATHING = 3'd2,
        MODE_WAVE      = 3'd3,
        MODE_RAINBOW   = 3'd4,
        MODE_PERKEY    = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        REG_MODE       = 3'd0,
        REG_BRIGHTNESS = 3'd1,
        REG_SPEED      = 3'd2,
        REG_DIRECTION  = 3'd3,
        REG_DAZZLE     = 3'd4,
        REG_RED        = 3'd5,
        REG_GREEN      = 3'd6,
        REG_BLUE       = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [2:0] bright_lvl;
        logic [2:0] speed_lvl;
        logic [1:0] direction;
        logic       dazzle;
        logic [7:0] base_r;
        logic [7:0] base_g;
        logic [7:0] base_b;
    } cfg_t;

    typedef struct packed {
        logic       sel_hsv;
        logic [7:0] hue;
        logic [7:0] val;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] k;
    } colour_t;

    // Value of a 16-bit product divided by 255, exact for any input up to 65279.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] y;
        begin
            y = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
            div255 = y[15:8];
        end
    endfunction

    // Rounded scale: (c*k + 128) / 255.
    function automatic logic [7:0] scale8(input logic [7:0] c, input logic [7:0] k);
        logic [16:0] p;
        begin
            p = {9'd0, c} * {9'd0, k} + 17'd128;
            scale8 = div255(p[15:0]);
        end
    endfunction

    function automatic logic [7:0] bright_of(input logic [2:0] lvl);
        case (lvl)
            3'd0:    bright_of = 8'd40;
            3'd1:    bright_of = 8'd90;
            3'd2:    bright_of = 8'd140;
            3'd3:    bright_of = 8'd195;
            default: bright_of = 8'd255;
        endcase
    endfunction

    // Phase rate is 8 << level, with levels above 4 taken as 4, so the phase is a bit slice of the time.
    function automatic logic [7:0] phase_of(input logic [31:0] t, input logic [2:0] lvl);
        case (lvl)
            3'd0:    phase_of = t[12:5];
            3'd1:    phase_of = t[11:4];
            3'd2:    phase_of = t[10:3];
            3'd3:    phase_of = t[9:2];
            default: phase_of = t[8:1];
        endcase
    endfunction

endpackage

`default_nettype wire

// ----- design/lepr_hsv.sv -----
// ---------------------------------------------------------------------------
// LED effect renderer hue stage
// Two-stage pipelined full-saturation HSV to RGB conversion with a pass
// path for colours that are only scaled.
// ---------------------------------------------------------------------------
`default_nettype none

module lepr_hsv
    import lepr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire logic       in_valid,
    input  wire colour_t    in_col,
    output logic            out_valid,
    output logic [7:0]      out_r,
    output logic [7:0]      out_g,
    output logic [7:0]      out_b
);

    logic       v1_reg;
    logic       hsv1_reg;
    logic [2:0] region1_reg;
    logic [7:0] val1_reg, q1_reg, t1_reg;
    logic [7:0] r1_reg, g1_reg, b1_reg, k1_reg;
    logic       v2_reg;
    logic [7:0] r2_reg, g2_reg, b2_reg;

    logic [2:0]  region_next;
    logic [7:0]  rem_next;
    logic [10:0] rsub;

    always_comb
    begin
        if (in_col.hue >= 8'd215)      region_next = 3'd5;
        else if (in_col.hue >= 8'd172) region_next = 3'd4;
        else if (in_col.hue >= 8'd129) region_next = 3'd3;
        else if (in_col.hue >= 8'd86)  region_next = 3'd2;
        else if (in_col.hue >= 8'd43)  region_next = 3'd1;
        else                           region_next = 3'd0;
        rsub = 11'(in_col.hue - 8'(region_next * 6'd43)) * 11'd6;
        rem_next = rsub[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // With full saturation p is zero; q and t reduce to single products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hsv1_reg    <= in_col.sel_hsv;
            region1_reg <= region_next;
            val1_reg    <= in_col.val;
            q1_reg      <= div255(in_col.val * (8'd255 - rem_next));
            t1_reg      <= div255(in_col.val * rem_next);
            r1_reg      <= in_col.r;
            g1_reg      <= in_col.g;
            b1_reg      <= in_col.b;
            k1_reg      <= in_col.k;
            if (hsv1_reg)
            begin
                case (region1_reg)
                    3'd0:    begin r2_reg <= val1_reg; g2_reg <= t1_reg; b2_reg <= 8'd0; end
                    3'd1:    begin r2_reg <= q1_reg; g2_reg <= val1_reg; b2_reg <= 8'd0; end
                    3'd2:    begin r2_reg <= 8'd0; g2_reg <= val1_reg; b2_reg <= t1_reg; end
                    3'd3:    begin r2_reg <= 8'd0; g2_reg <= q1_reg; b2_reg <= val1_reg; end
                    3'd4:    begin r2_reg <= t1_reg; g2_reg <= 8'd0; b2_reg <= val1_reg; end
                    default: begin r2_reg <= val1_reg; g2_reg <= 8'd0; b2_reg <= q1_reg; end
                endcase
            end
            else
            begin
                r2_reg <= scale8(r1_reg, k1_reg);
                g2_reg <= scale8(g1_reg, k1_reg);
                b2_reg <= scale8(b1_reg, k1_reg);
            end
        end
    end

    assign out_valid = v2_reg;
    assign out_r     = r2_reg;
    assign out_g     = g2_reg;
    assign out_b     = b2_reg;

endmodule

`default_nettype wire

// ----- design/led_effect_pixel_renderer.sv -----
// ---------------------------------------------------------------------------
// LED effect pixel renderer
// Renders one LED colour per word from frame time, position and picture.
// ---------------------------------------------------------------------------
// The renderer takes one pixel word per cycle unless the output stalls, and
// presents its colour on the output through a four-stage pipeline (phase and
// position, envelope scale, hue region products, final select). The whole
// pipeline advances only when the output register is free or being taken, so
// a stall holds every stage. Configuration must be written only while the
// pipeline is empty.
`default_nettype none

module led_effect_pixel_renderer
    import lepr_pkg::*;
#(
    parameter int ROW_MAX = 5,
    parameter int COL_MAX = 15
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // time_ms[31:0], led_row[34:32], led_col[38:35], pic_red[46:39],
    // pic_green[54:47], pic_blue[62:55], pic_present[63]
    input  wire logic [63:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16]
    output logic [23:0]      m_axis_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    cfg_t cfg_reg;
    logic en;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_MODE:       cfg_reg.mode       <= cfg_data[2:0];
                REG_BRIGHTNESS: cfg_reg.bright_lvl <= cfg_data[2:0];
                REG_SPEED:      cfg_reg.speed_lvl  <= cfg_data[2:0];
                REG_DIRECTION:  cfg_reg.direction  <= cfg_data[1:0];
                REG_DAZZLE:     cfg_reg.dazzle     <= cfg_data[0];
                REG_RED:        cfg_reg.base_r     <= cfg_data;
                REG_GREEN:      cfg_reg.base_g     <= cfg_data;
                REG_BLUE:       cfg_reg.base_b     <= cfg_data;
                default:        ;
            endcase
        end
    end

    logic [31:0] in_time;
    logic [2:0]  in_row;
    logic [3:0]  in_col;
    logic [7:0]  in_pr, in_pg, in_pb;
    logic        in_present;
    assign in_time    = s_axis_tdata[31:0];
    assign in_row     = s_axis_tdata[34:32];
    assign in_col     = s_axis_tdata[38:35];
    assign in_pr      = s_axis_tdata[46:39];
    assign in_pg      = s_axis_tdata[54:47];
    assign in_pb      = s_axis_tdata[62:55];
    assign in_present = s_axis_tdata[63];

    // Hue offsets of every row and column, fixed at elaboration; offsets of
    // positions beyond the maxima wrap to their low eight bits.
    logic [7:0] row_pos_tab [8];
    logic [7:0] col_pos_tab [16];

    for (genvar gi = 0; gi < 8; gi++)
    begin : g_row_pos
        assign row_pos_tab[gi] = 8'((gi * 255) / ROW_MAX);
    end

    for (genvar gj = 0; gj < 16; gj++)
    begin : g_col_pos
        assign col_pos_tab[gj] = 8'((gj * 255) / COL_MAX);
    end

    // Stage 0: phase, position and triangle envelope.
    logic [7:0] ph_next, tri_next, pos_next;
    always_comb
    begin
        ph_next  = phase_of(in_time, cfg_reg.speed_lvl);
        tri_next = ph_next[7] ? {~ph_next[6:0], 1'b0} : {ph_next[6:0], 1'b0};
        if (cfg_reg.direction[1])
            pos_next = row_pos_tab[in_row];
        else
            pos_next = col_pos_tab[in_col];
    end

    logic       v0_reg;
    logic [7:0] ph0_reg, tri0_reg, pos0_reg, pr0_reg, pg0_reg, pb0_reg;
    logic       pres0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph0_reg   <= ph_next;
            tri0_reg  <= tri_next;
            pos0_reg  <= pos_next;
            pr0_reg   <= in_pr;
            pg0_reg   <= in_pg;
            pb0_reg   <= in_pb;
            pres0_reg <= in_present;
        end
    end

    // Stage 1: envelope level and per-mode colour setup.
    colour_t    col_next;
    logic [7:0] bri;
    always_comb
    begin
        bri = bright_of(cfg_reg.bright_lvl);
        col_next = '0;
        case (cfg_reg.mode)
            MODE_OFF: ;
            MODE_BREATHING:
            begin
                col_next.val = scale8(bri, tri0_reg);
                col_next.hue = ph0_reg;
                col_next.sel_hsv = cfg_reg.dazzle;
                col_next.r = cfg_reg.base_r;
                col_next.g = cfg_reg.base_g;
                col_next.b = cfg_reg.base_b;
                col_next.k = col_next.val;
            end
            MODE_WAVE:
            begin
                col_next.sel_hsv = 1'b1;
                col_next.val = bri;
                col_next.hue = cfg_reg.direction[0] ? ph0_reg - pos0_reg
                                                    : ph0_reg + pos0_reg;
            end
            MODE_RAINBOW:
            begin
                col_next.sel_hsv = 1'b1;
                col_next.val = bri;
                col_next.hue = ph0_reg;
            end
            MODE_PERKEY:
            begin
                if (pres0_reg)
                begin
                    col_next.r = pr0_reg;
                    col_next.g = pg0_reg;
                    col_next.b = pb0_reg;
                    col_next.k = bri;
                end
            end
            default:
            begin
                col_next.r = cfg_reg.base_r;
                col_next.g = cfg_reg.base_g;
                col_next.b = cfg_reg.base_b;
                col_next.k = bri;
            end
        endcase
    end

    logic    v1_reg;
    colour_t col1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            col1_reg <= col_next;
    end

    logic       hv;
    logic [7:0] hr, hg, hb;

    lepr_hsv u_hsv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v1_reg),
        .in_col    (col1_reg),
        .out_valid (hv),
        .out_r     (hr),
        .out_g     (hg),
        .out_b     (hb)
    );

    assign m_axis_tvalid = hv;
    assign m_axis_tdata  = {hb, hg, hr};

endmodule

`default_nettype wire

// ----- design/lepr_checker.sv -----
// ---------------------------------------------------------------------------
// LED effect renderer checker
// Port-level checks of the pixel renderer, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module lepr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic        cfg_ready
);

    // A word waiting at the output holds its data.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // The input side is stalled exactly when the output word is stalled.
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    // A word accepted while the pipeline keeps advancing appears at the output.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready ##1 s_axis_tready ##1 s_axis_tready
        ##1 s_axis_tready |=> m_axis_tvalid)
        else $error("accepted word did not arrive");

    a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("config port not ready");

endmodule

bind led_effect_pixel_renderer lepr_checker u_lepr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_ready     (cfg_ready)
);

`default_nettype wire

// ----- tb/led_effect_pixel_renderer_checker.sv -----
// ---------------------------------------------------------------------------
// LED effect pixel renderer checker
// Watches the pixel, colour and register channels, predicts each colour
// and compares it with the colour the renderer returns.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module led_effect_pixel_renderer_checker
    import lepr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output int          fail_count,
    output int          pending_count
);

    localparam int ROW_LIMIT = 5;
    localparam int COL_LIMIT = 15;

    logic [2:0] mode_r, bright_r, speed_r;
    logic [1:0] dir_r;
    logic       dazzle_r;
    logic [7:0] red_r, green_r, blue_r;

    logic [23:0] colour_q[$];

    function automatic logic [7:0] rscale(input int unsigned c, input int unsigned k);
        rscale = 8'((c * k + 128) / 255);
    endfunction

    function automatic logic [23:0] hsv_colour(input int unsigned h, input int unsigned v);
        int unsigned region, rem, p, q, t;
        logic [7:0] r, g, b;
        region = h / 43;
        rem = ((h - region * 43) * 6) & 255;
        p = 0;
        q = (v * (255 - (255 * rem) / 255)) / 255;
        t = (v * (255 - (255 * (255 - rem)) / 255)) / 255;
        case (region)
            0: begin r = 8'(v); g = 8'(t); b = 8'(p); end
            1: begin r = 8'(q); g = 8'(v); b = 8'(p); end
            2: begin r = 8'(p); g = 8'(v); b = 8'(t); end
            3: begin r = 8'(p); g = 8'(q); b = 8'(v); end
            4: begin r = 8'(t); g = 8'(p); b = 8'(v); end
            default: begin r = 8'(v); g = 8'(p); b = 8'(q); end
        endcase
        hsv_colour = {b, g, r};
    endfunction

    function automatic logic [23:0] render_pixel(input logic [63:0] px);
        logic [31:0] tm, prod;
        int unsigned row, col, bri, ph, env, v, pos, hue, lvl;
        logic [23:0] c;
        tm = px[31:0];
        row = 32'(px[34:32]);
        col = 32'(px[38:35]);
        lvl = (speed_r > 4) ? 4 : 32'(speed_r);
        case ((bright_r > 4) ? 4 : 32'(bright_r))
            0: bri = 40;
            1: bri = 90;
            2: bri = 140;
            3: bri = 195;
            default: bri = 255;
        endcase
        prod = tm * (32'd8 << lvl);
        ph = (prod >> 8) & 255;
        c = '0;
        case (mode_r)
            MODE_OFF: c = '0;
            MODE_BREATHING:
            begin
                env = (ph < 128) ? (ph * 2) & 255 : ((255 - ph) * 2) & 255;
                v = 32'(rscale(bri, env));
                if (dazzle_r)
                    c = hsv_colour(ph, v);
                else
                    c = {rscale(blue_r, v), rscale(green_r, v), rscale(red_r, v)};
            end
            MODE_WAVE:
            begin
                pos = dir_r[1] ? ((row * 255) / ROW_LIMIT) & 255
                               : ((col * 255) / COL_LIMIT) & 255;
                hue = dir_r[0] ? (ph - pos) & 255 : (ph + pos) & 255;
                c = hsv_colour(hue, bri);
            end
            MODE_RAINBOW: c = hsv_colour(ph, bri);
            MODE_PERKEY:
                if (px[63])
                    c = {rscale(px[62:55], bri), rscale(px[54:47], bri),
                         rscale(px[46:39], bri)};
            default: c = {rscale(blue_r, bri), rscale(green_r, bri), rscale(red_r, bri)};
        endcase
        render_pixel = c;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    initial fail_count = 0;
    assign pending_count = colour_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_r = '0; bright_r = '0; speed_r = '0; dir_r = '0;
            dazzle_r = 1'b0; red_r = '0; green_r = '0; blue_r = '0;
        end
        else
        begin
            logic [23:0] want;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (colour_q.size() == 0)
                    report_mismatch($sformatf("unexpected word %h", m_axis_tdata));
                else
                begin
                    want = colour_q.pop_front();
                    if (m_axis_tdata[7:0] !== want[7:0])
                        report_mismatch($sformatf("red %h want %h", m_axis_tdata[7:0], want[7:0]));
                    if (m_axis_tdata[15:8] !== want[15:8])
                        report_mismatch($sformatf("green %h want %h",
                                                  m_axis_tdata[15:8], want[15:8]));
                    if (m_axis_tdata[23:16] !== want[23:16])
                        report_mismatch($sformatf("blue %h want %h",
                                                  m_axis_tdata[23:16], want[23:16]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                colour_q.push_back(render_pixel(s_axis_tdata));
            if (cfg_valid && cfg_ready)
                case (reg_idx_t'(cfg_index))
                    REG_MODE:       mode_r = cfg_data[2:0];
                    REG_BRIGHTNESS: bright_r = cfg_data[2:0];
                    REG_SPEED:      speed_r = cfg_data[2:0];
                    REG_DIRECTION:  dir_r = cfg_data[1:0];
                    REG_DAZZLE:     dazzle_r = cfg_data[0];
                    REG_RED:        red_r = cfg_data;
                    REG_GREEN:      green_r = cfg_data;
                    REG_BLUE:       blue_r = cfg_data;
                    default:        ;
                endcase
        end
    end

endmodule

// ----- tb/led_effect_pixel_renderer_tb.sv -----
// ---------------------------------------------------------------------------
// LED effect pixel renderer testbench
// Sweeps every effect mode and register extreme with directed and random
// pixel words under random stalls; the checker does the comparison.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module led_effect_pixel_renderer_tb;
    import lepr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;
    int          fail_count, pending_count;
    int          cycle_count = 0;
    bit          steady = 1'b0;

    always #4 clk = ~clk;

    led_effect_pixel_renderer DUT (.*);

    led_effect_pixel_renderer_checker u_checker (.*);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("led_effect_pixel_renderer_tb NOT OK");
            $finish;
        end
    end

    // The receiver stalls about 11 words in a hundred except in steady stretches.
    always @(negedge clk)
        m_axis_tready <= steady || ($urandom_range(99) >= 11);

    task automatic write_reg(input reg_idx_t idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stops sending and waits until every expected colour is back.
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic send_pixel(input logic [63:0] px);
        while (!steady && $urandom_range(99) < 11)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= px;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    function automatic logic [63:0] random_pixel();
        logic [63:0] px;
        px = {$urandom, $urandom};
        // Mostly positions on the panel, a few beyond it.
        if ($urandom_range(9) != 0)
        begin
            px[34:32] = 3'($urandom_range(5));
        end
        return px;
    endfunction

    task automatic random_settings(input int ph);
        write_reg(REG_MODE, 8'($urandom_range(7)));
        write_reg(REG_BRIGHTNESS, (ph % 4 == 0) ? 8'd0 : (ph % 4 == 1) ? 8'd7 : 8'($urandom));
        write_reg(REG_SPEED, (ph % 3 == 0) ? 8'd0 : (ph % 3 == 1) ? 8'd7 : 8'($urandom));
        write_reg(REG_DIRECTION, 8'($urandom));
        write_reg(REG_DAZZLE, 8'($urandom));
        write_reg(REG_RED, (ph % 5 == 0) ? 8'hFF : 8'($urandom));
        write_reg(REG_GREEN, (ph % 5 == 1) ? 8'h00 : 8'($urandom));
        write_reg(REG_BLUE, 8'($urandom));
    endtask

    initial
    begin
        logic [63:0] px;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: each mode with field extremes and special cases.
        write_reg(REG_BRIGHTNESS, 8'd4);
        write_reg(REG_RED, 8'hFF);
        write_reg(REG_GREEN, 8'h80);
        write_reg(REG_BLUE, 8'h01);
        for (int m = 0; m < 8; m++)
        begin
            drain_pipeline();
            write_reg(REG_MODE, 8'(m));
            write_reg(REG_DIRECTION, 8'(m & 3));
            write_reg(REG_DAZZLE, 8'(m & 1));
            send_pixel('0);
            send_pixel('1);
            px = '1; px[63] = 1'b0;
            send_pixel(px);
        end
        // A row beyond its maximum and the last column in wave mode.
        drain_pipeline();
        write_reg(REG_MODE, 8'(MODE_WAVE));
        write_reg(REG_DIRECTION, 8'd2);
        send_pixel({25'd0, 4'd0, 3'd7, 32'h1234});
        drain_pipeline();
        write_reg(REG_DIRECTION, 8'd1);
        send_pixel({25'd0, 4'd15, 3'd0, 32'h8000});

        for (int ph = 0; ph < 27; ph++)
        begin
            drain_pipeline();
            random_settings(ph);
            steady = (ph == 13);
            for (int i = 0; i < 50; i++)
            begin
                send_pixel(random_pixel());
                // Hold off the sender until every colour is back.
                if (ph == 5 && i == 25)
                    drain_pipeline();
            end
        end
        drain_pipeline();
        if (fail_count == 0)
            $display("led_effect_pixel_renderer_tb OK");
        else
            $display("led_effect_pixel_renderer_tb NOT OK");
        $finish;
    end

endmodule
